### hw/rtl/cst_pkg.sv
// Shared types and constants for the clip sequence step timer.
package cst_pkg;

	// Width of the configuration address and data buses.
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Width of step indexes as they appear in the payloads.
	localparam int STEP_W = 4;

	// Width of the step count register.
	localparam int COUNT_W = 5;

	// Q16.16 time width.
	localparam int TIME_W = 32;

	// Largest representable time; accumulators saturate here.
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// Item operation codes.
	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	// Register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_STEPS_IN_USE    = 2'd0,
		REG_LOOP_ENABLE     = 2'd1,
		REG_CROSSFADE_LEN   = 2'd2
	} reg_idx_t;

	// One input item.
	typedef struct packed {
		op_t               operation;
		logic [STEP_W-1:0] step_slot;
		logic [TIME_W-1:0] time_value;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic [STEP_W-1:0] active_step;
		logic [TIME_W-1:0] time_in_step;
		logic              fading;
		logic [STEP_W-1:0] fade_source_step;
		logic [TIME_W-1:0] fade_time;
		logic              step_moved;
		logic              holding_end;
	} rsp_t;

	// Configuration seen by the datapath.
	typedef struct packed {
		logic [COUNT_W-1:0] steps_in_use;
		logic               loop_enable;
		logic [TIME_W-1:0]  crossfade_length;
	} cfg_t;

endpackage

### hw/rtl/cst_apb_regs.sv
// Configuration register file behind the APB-style port.
module cst_apb_regs
	import cst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic     wr_en;
	reg_idx_t reg_sel;
	cfg_t     cfg_q;

	// Registers are word aligned, so the index is the upper address bits.
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_STEPS_IN_USE:  cfg_q.steps_in_use     <= pwdata[COUNT_W-1:0];
				REG_LOOP_ENABLE:   cfg_q.loop_enable      <= pwdata[0];
				REG_CROSSFADE_LEN: cfg_q.crossfade_length <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data mux; unmapped addresses read as zero.
	always_comb begin
		case (reg_sel)
			REG_STEPS_IN_USE:  prdata = APB_DW'(cfg_q.steps_in_use);
			REG_LOOP_ENABLE:   prdata = APB_DW'(cfg_q.loop_enable);
			REG_CROSSFADE_LEN: prdata = APB_DW'(cfg_q.crossfade_length);
			default:           prdata = '0;
		endcase
	end

endmodule

### hw/rtl/clip_sequence_step_timer.sv
// Top level of the clip sequence step timer: step table, timing state and result register.
//
//   Channel   Direction  Handshake              Payload
//   cmd       in         cmd_valid / cmd_stall  cmd_t (operation, step_slot, time_value)
//   rsp       out        rsp_valid / rsp_stall  rsp_t (step, times, fade and end flags)
//   config    in         APB-style, pready = 1  steps_in_use, loop_enable, crossfade_length
//
// Each accepted command is answered next cycle; one command per cycle unless stalled.
// The step table's read is registered: the duration of the step that
// becomes current is fetched at the same edge that the transaction updates the state.
// cmd_stall is high only while a response is held in the output register under rsp_stall.
// Reset clears the timing state and configuration; the step table is not cleared.
module clip_sequence_step_timer
	import cst_pkg::*;
#(
	parameter int MAX_STEPS = 16
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_t              cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// Index width of the step table, and a width that holds both indexes and slots.
	localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int SW    = (IDX_W > STEP_W) ? IDX_W : STEP_W;
	// Width that holds step counts up to MAX_STEPS and the count register.
	localparam int CNT_W = $clog2(MAX_STEPS + 1);
	localparam int KW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	cfg_t cfg;

	// Timing state.
	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] elapsed_q;
	logic              fade_act_q;
	logic [IDX_W-1:0]  fade_org_q;
	logic [TIME_W-1:0] fade_el_q;

	// Step table and the registered duration of the current step.
	logic [TIME_W-1:0] step_mem [MAX_STEPS];
	logic [TIME_W-1:0] dur_q;

	// Result register.
	logic rsp_valid_q;
	rsp_t rsp_q;

	// Next-state and datapath signals.
	logic              accept;
	logic              is_adv;
	logic              tbl_we;
	logic [SW-1:0]     slot_w;
	logic [SW-1:0]     rd_w;
	logic [KW-1:0]     count_k;
	logic [KW-1:0]     next_k;
	logic              at_last;
	logic [TIME_W:0]   el_sum;
	logic [TIME_W:0]   fd_sum;
	logic [TIME_W-1:0] el_sat;
	logic [TIME_W-1:0] fd_sat;
	logic              at_end;
	logic [IDX_W-1:0]  n_idx;
	logic [TIME_W-1:0] n_elapsed;
	logic              n_fade_act;
	logic [IDX_W-1:0]  n_fade_org;
	logic [TIME_W-1:0] n_fade_el;
	logic              moved;
	logic              holding;
	logic [SW-1:0]     n_idx_w;
	logic [SW-1:0]     n_org_w;

	cst_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The output register frees up whenever its response is taken.
	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign accept    = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Effective step count, capped at the table depth.
	always_comb begin
		if (KW'(cfg.steps_in_use) > KW'(MAX_STEPS)) begin
			count_k = KW'(MAX_STEPS);
		end else begin
			count_k = KW'(cfg.steps_in_use);
		end
	end

	// Saturating accumulators and end-of-step detection.
	assign el_sum  = {1'b0, elapsed_q} + {1'b0, cmd.time_value};
	assign fd_sum  = {1'b0, fade_el_q} + {1'b0, cmd.time_value};
	assign el_sat  = el_sum[TIME_W] ? TIME_MAX : el_sum[TIME_W-1:0];
	assign fd_sat  = fd_sum[TIME_W] ? TIME_MAX : fd_sum[TIME_W-1:0];
	assign at_end  = (dur_q != '0) && (el_sat >= dur_q);
	assign next_k  = KW'(idx_q) + KW'(1);
	assign at_last = next_k >= count_k;
	assign is_adv  = (cmd.operation == OP_ADVANCE) && (count_k != '0);

	// Sequencing decision for one transaction.
	always_comb begin
		n_idx      = idx_q;
		n_elapsed  = elapsed_q;
		n_fade_act = fade_act_q;
		n_fade_org = fade_org_q;
		n_fade_el  = fade_el_q;
		moved      = 1'b0;
		holding    = 1'b0;
		if (is_adv) begin
			n_elapsed = el_sat;
			if (fade_act_q) begin
				n_fade_el  = fd_sat;
				n_fade_act = !(fd_sat >= cfg.crossfade_length);
			end
			if (at_end) begin
				if (at_last && !cfg.loop_enable) begin
					// Non-looping sequence clamps at the end of its final step.
					n_elapsed = dur_q;
					holding   = 1'b1;
				end else begin
					n_fade_act = (cfg.crossfade_length != '0);
					n_fade_org = idx_q;
					n_fade_el  = '0;
					n_idx      = at_last ? '0 : next_k[IDX_W-1:0];
					n_elapsed  = '0;
					moved      = 1'b1;
				end
			end
		end
	end

	// Table write and read addresses.
	assign slot_w  = SW'(cmd.step_slot);
	assign tbl_we  = accept && (cmd.operation == OP_LOAD) &&
		({1'b0, slot_w} < (SW+1)'(MAX_STEPS));
	assign rd_w    = accept ? SW'(n_idx) : SW'(idx_q);
	assign n_idx_w = SW'(n_idx);
	assign n_org_w = SW'(n_fade_org);

	// Step table with a registered read of the step that is current next cycle.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			step_mem[slot_w[IDX_W-1:0]] <= cmd.time_value;
		end
		if (tbl_we && (slot_w == rd_w)) begin
			dur_q <= cmd.time_value;
		end else begin
			dur_q <= step_mem[rd_w[IDX_W-1:0]];
		end
	end

	// Timing state and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			elapsed_q   <= '0;
			fade_act_q  <= 1'b0;
			fade_org_q  <= '0;
			fade_el_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q      <= n_idx;
				elapsed_q  <= n_elapsed;
				fade_act_q <= n_fade_act;
				fade_org_q <= n_fade_org;
				fade_el_q  <= n_fade_el;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload, loaded with each accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.active_step      <= n_idx_w[STEP_W-1:0];
			rsp_q.time_in_step     <= n_elapsed;
			rsp_q.fading           <= n_fade_act;
			rsp_q.fade_source_step <= n_org_w[STEP_W-1:0];
			rsp_q.fade_time        <= n_fade_el;
			rsp_q.step_moved       <= moved;
			rsp_q.holding_end      <= holding;
		end
	end

endmodule

### tb/clip_sequence_step_timer_test.sv
// Self-checking testbench for the clip sequence step timer: random stepping, fades and holds.
module clip_sequence_step_timer_test;
	import cst_pkg::*;

	localparam int MAX_STEPS = 16;

	// Idle patterns applied to the command and response channels.
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	// Commands waiting to be driven and the timer states expected back.
	cmd_t queued_timer_cmds[$];
	rsp_t expected_timer_states[$];

	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;
	int unsigned error_count = 0;

	// Shadow of the timer state and its configuration.
	logic [TIME_W-1:0] step_len_tbl [MAX_STEPS];
	logic [STEP_W-1:0] cur_step = '0;
	logic [TIME_W-1:0] in_step_time = '0;
	logic fade_on = 1'b0;
	logic [STEP_W-1:0] fade_from = '0;
	logic [TIME_W-1:0] fade_elapsed_t = '0;
	logic [COUNT_W-1:0] cfg_steps = '0;
	logic cfg_loop = 1'b0;
	logic [TIME_W-1:0] cfg_fade_len = '0;

	clip_sequence_step_timer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	// Saturating Q16.16 addition.
	function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	// Applies one command to the shadow state and returns the state it reports.
	function automatic rsp_t predict_timer_step(cmd_t c);
		logic [COUNT_W-1:0] cnt;
		logic [COUNT_W-1:0] next;
		logic [TIME_W-1:0] dur;
		logic moved;
		logic holding;
		rsp_t r;
		moved = 1'b0;
		holding = 1'b0;
		if (c.operation == OP_LOAD) begin
			step_len_tbl[c.step_slot] = c.time_value;
		end else begin
			cnt = (cfg_steps > MAX_STEPS) ? COUNT_W'(MAX_STEPS) : cfg_steps;
			if (cnt != 0) begin
				in_step_time = sat_sum(in_step_time, c.time_value);
				if (fade_on) begin
					fade_elapsed_t = sat_sum(fade_elapsed_t, c.time_value);
					if (fade_elapsed_t >= cfg_fade_len)
						fade_on = 1'b0;
				end
				dur = step_len_tbl[cur_step];
				if (dur != 0 && in_step_time >= dur) begin
					next = {1'b0, cur_step} + 1'b1;
					// Past the last step (or a step beyond a lowered count) wraps or holds.
					if (next >= cnt) begin
						if (!cfg_loop) begin
							in_step_time = dur;
							holding = 1'b1;
						end else begin
							next = '0;
						end
					end
					if (!holding) begin
						fade_on = (cfg_fade_len != 0);
						fade_from = cur_step;
						fade_elapsed_t = '0;
						cur_step = next[STEP_W-1:0];
						in_step_time = '0;
						moved = 1'b1;
					end
				end
			end
		end
		r.active_step = cur_step;
		r.time_in_step = in_step_time;
		r.fading = fade_on;
		r.fade_source_step = fade_from;
		r.fade_time = fade_elapsed_t;
		r.step_moved = moved;
		r.holding_end = holding;
		return r;
	endfunction

	task automatic compare_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
		if (want !== got) begin
			if (error_count < 40)
				$display("%0t: %s expected %h got %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Driver: presents queued commands, holding each one while stalled.
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || !cmd_stall) begin
			if (queued_timer_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd_valid <= 1'b1;
				cmd <= queued_timer_cmds.pop_front();
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Response side stalls at random.
	always @(posedge clk) begin
		rsp_stall <= arst_n && ($urandom_range(99) < rsp_stall_pct);
	end

	// Monitor: tracks register writes, predicts each accepted command, checks responses.
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			cur_step = '0;
			in_step_time = '0;
			fade_on = 1'b0;
			fade_from = '0;
			fade_elapsed_t = '0;
			cfg_steps = '0;
			cfg_loop = 1'b0;
			cfg_fade_len = '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_STEPS_IN_USE: cfg_steps = pwdata[COUNT_W-1:0];
					REG_LOOP_ENABLE: cfg_loop = pwdata[0];
					REG_CROSSFADE_LEN: cfg_fade_len = pwdata;
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall)
				expected_timer_states.push_back(predict_timer_step(cmd));
			if (rsp_valid && !rsp_stall) begin
				if (expected_timer_states.size() == 0) begin
					if (error_count < 40)
						$display("%0t: unexpected response %h", $time, rsp);
					error_count++;
				end else begin
					want = expected_timer_states.pop_front();
					compare_field("active_step", TIME_W'(want.active_step),
						TIME_W'(rsp.active_step));
					compare_field("time_in_step", want.time_in_step, rsp.time_in_step);
					compare_field("fading", TIME_W'(want.fading), TIME_W'(rsp.fading));
					compare_field("fade_source_step", TIME_W'(want.fade_source_step),
						TIME_W'(rsp.fade_source_step));
					compare_field("fade_time", want.fade_time, rsp.fade_time);
					compare_field("step_moved", TIME_W'(want.step_moved),
						TIME_W'(rsp.step_moved));
					compare_field("holding_end", TIME_W'(want.holding_end),
						TIME_W'(rsp.holding_end));
				end
			end
		end
	end

	task automatic queue_cmd(op_t op, logic [STEP_W-1:0] slot, logic [TIME_W-1:0] tv);
		cmd_t c;
		c.operation = op;
		c.step_slot = slot;
		c.time_value = tv;
		queued_timer_cmds.push_back(c);
	endtask

	// Waits until every queued command has been answered, then lets the block settle.
	task automatic wait_timer_idle();
		while (queued_timer_cmds.size() != 0 || cmd_valid || expected_timer_states.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_idle_mode(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				rsp_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 80;
				rsp_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				rsp_stall_pct = 80;
			end
			default: begin
				send_idle_pct = 7;
				rsp_stall_pct = 7;
			end
		endcase
	endtask

	// One configuration followed by random loads and advances, with a full drain halfway.
	task automatic run_timer_phase(logic [COUNT_W-1:0] steps, logic loop,
		logic [TIME_W-1:0] fade_len, idle_mode_t mode, int unsigned n_items);
		logic [TIME_W-1:0] tv;
		logic [STEP_W-1:0] slot;
		int unsigned k;
		wait_timer_idle();
		write_reg(REG_STEPS_IN_USE, APB_DW'(steps));
		write_reg(REG_LOOP_ENABLE, APB_DW'(loop));
		write_reg(REG_CROSSFADE_LEN, fade_len);
		set_idle_mode(mode);
		for (k = 0; k < n_items; k++) begin
			if (k == n_items / 2)
				wait_timer_idle();
			slot = STEP_W'($urandom_range(MAX_STEPS - 1));
			if ($urandom_range(99) < 30) begin
				// Mostly short durations so that steps end often.
				case ($urandom_range(19))
					0: tv = '0;
					1: tv = TIME_MAX;
					2, 3: tv = $urandom;
					default: tv = $urandom_range(32'h30000, 1);
				endcase
				queue_cmd(OP_LOAD, slot, tv);
			end else begin
				case ($urandom_range(19))
					0: tv = TIME_MAX;
					1, 2: tv = $urandom;
					3: tv = '0;
					default: tv = $urandom_range(32'h18000);
				endcase
				queue_cmd(OP_ADVANCE, slot, tv);
			end
		end
	endtask

	// Stimulus and end of run.
	initial begin
		int unsigned k;
		logic [TIME_W-1:0] dur;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero steps in use: advances change nothing and read no table entry.
		queue_cmd(OP_ADVANCE, 4'd0, TIME_MAX);
		queue_cmd(OP_ADVANCE, 4'd15, '0);
		// Fill the whole table, including a step that never ends and the longest step.
		for (k = 0; k < MAX_STEPS; k++) begin
			dur = (k == 0) ? 32'h10000 : (k == 1) ? 32'h20000 : (k == 2) ? 32'h8000 :
				(k == 3) ? 32'h0 : (k == MAX_STEPS - 1) ? TIME_MAX : 32'h4000 * (k + 1);
			queue_cmd(OP_LOAD, STEP_W'(k), dur);
		end
		wait_timer_idle();
		write_reg(REG_STEPS_IN_USE, 32'd3);
		write_reg(REG_LOOP_ENABLE, 32'd0);
		write_reg(REG_CROSSFADE_LEN, 32'h10000);
		// Step ends, fade runs and ends, saturation, then holding at the final step.
		queue_cmd(OP_ADVANCE, 4'd0, 32'h10000);
		queue_cmd(OP_ADVANCE, 4'd0, 32'h8000);
		queue_cmd(OP_ADVANCE, 4'd0, 32'h18000);
		queue_cmd(OP_ADVANCE, 4'd0, TIME_MAX);
		queue_cmd(OP_ADVANCE, 4'd0, '0);

		run_timer_phase(5'd1, 1'b1, 32'h0, IDLE_NONE, 100);
		run_timer_phase(5'd16, 1'b1, 32'h18000, IDLE_SENDER, 100);
		run_timer_phase(5'd31, 1'b0, TIME_MAX, IDLE_RECEIVER, 100);
		run_timer_phase(5'd2, 1'b0, 32'h1, IDLE_BOTH, 100);
		run_timer_phase(5'd5, 1'b1, 32'h30000, IDLE_NONE, 100);
		run_timer_phase(5'd16, 1'b0, 32'h0, IDLE_SENDER, 100);
		run_timer_phase(5'd0, 1'b1, 32'h10000, IDLE_RECEIVER, 100);
		run_timer_phase(5'd1, 1'b0, 32'h8000, IDLE_BOTH, 100);
		run_timer_phase(5'd8, 1'b1, TIME_MAX, IDLE_NONE, 100);
		run_timer_phase(5'd4, 1'b1, 32'h20000, IDLE_SENDER, 100);
		run_timer_phase(5'd3, 1'b0, 32'h40000, IDLE_RECEIVER, 100);
		run_timer_phase(5'd16, 1'b1, 32'h1, IDLE_BOTH, 100);
		wait_timer_idle();
		repeat (10) @(posedge clk);

		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(8 * 300000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
